@@ hdl/cpc_pkg.sv @@
// shared constants, types and arctangent table of the cartesian / polar converter
`timescale 1ns / 1ps
package cpc_pkg;

    localparam int ITERATIONS  = 16;
    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_WIDTH = 17;
    localparam int FRAC_BITS   = 8;
    // datapath width: coordinate, extra fraction bits, sign and cordic growth
    localparam int DW          = COORD_WIDTH + FRAC_BITS + 3;
    // internal angle width, degrees * 65536
    localparam int ZW          = 27;
    localparam int GAIN_WIDTH  = 30;
    localparam int GAIN_FRAC   = 30;
    localparam int MPROD_W     = COORD_WIDTH + GAIN_WIDTH;
    localparam int XPROD_W     = DW - 1 + GAIN_WIDTH;

    // conversion kinds
    localparam logic KIND_RECT  = 1'b0;
    localparam logic KIND_POLAR = 1'b1;

    // cordic gain compensation, 0.6072529350 in q0.30
    localparam logic [GAIN_WIDTH-1:0] GAIN = GAIN_WIDTH'(652032874);

    localparam logic [ANGLE_WIDTH-1:0] ANGLE_FULL = ANGLE_WIDTH'(92160);
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_Q1   = ANGLE_WIDTH'(23040);
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_Q3   = ANGLE_WIDTH'(69120);

    localparam logic signed [ZW-1:0] Z_180 = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] Z_360 = ZW'(360 * 65536);

    typedef struct packed {
        logic                   valid;
        logic                   kind;
        logic                   origin;
        logic                   flip;
        logic [ANGLE_WIDTH-1:0] angle;
        logic signed [DW-1:0]   x;
        logic signed [DW-1:0]   y;
        logic signed [ZW-1:0]   z;
    } t_cord;

    // atan(2^-i) in degrees * 65536, rounded
    function automatic logic signed [ZW-1:0] cpc_atan(input int idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:       v = ZW'(2949120);
            1:       v = ZW'(1740967);
            2:       v = ZW'(919879);
            3:       v = ZW'(466945);
            4:       v = ZW'(234379);
            5:       v = ZW'(117304);
            6:       v = ZW'(58666);
            7:       v = ZW'(29335);
            8:       v = ZW'(14668);
            9:       v = ZW'(7334);
            10:      v = ZW'(3667);
            11:      v = ZW'(1833);
            12:      v = ZW'(917);
            13:      v = ZW'(458);
            14:      v = ZW'(229);
            15:      v = ZW'(115);
            16:      v = ZW'(57);
            17:      v = ZW'(29);
            18:      v = ZW'(14);
            19:      v = ZW'(7);
            20:      v = ZW'(4);
            21:      v = ZW'(2);
            22:      v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/cartesian_polar_converter.sv @@
// top level of the pipelined cartesian / polar converter
`timescale 1ns / 1ps
// usage:
//   a transaction is taken at each rising edge with start high and busy low.
//   busy is always low: the pipeline takes one transaction every cycle.
//   i_kind = 1 converts (i_in_x, i_in_y) to magnitude and angle in [0,360) deg;
//   i_kind = 0 converts (i_in_magnitude, i_in_angle) to x and y with clipping.
//   angles are degrees * 256; an input angle at or above 360 deg wraps once.
//   the result passes two setup stages, one stage per cordic iteration and two
//   finish stages before it is shown on the o_ ports.
//   throughput: one result per cycle, set by the unrolled cordic stages.
//   each result is on the o_ ports for exactly one cycle with o_valid high;
//   the receiver cannot stall, so results are never held.
//   unused fields are zero, except o_out_angle which echoes the reduced angle
//   for polar to rectangular.
//   reset (synchronous, active low) drops every transaction in flight.
module cartesian_polar_converter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_kind,
    input  logic signed [cpc_pkg::COORD_WIDTH-1:0] i_in_x,
    input  logic signed [cpc_pkg::COORD_WIDTH-1:0] i_in_y,
    input  logic        [cpc_pkg::COORD_WIDTH-1:0] i_in_magnitude,
    input  logic        [cpc_pkg::ANGLE_WIDTH-1:0] i_in_angle,
    output logic                                 o_valid,
    output logic                                 o_out_kind,
    output logic signed [cpc_pkg::COORD_WIDTH-1:0] o_out_x,
    output logic signed [cpc_pkg::COORD_WIDTH-1:0] o_out_y,
    output logic        [cpc_pkg::COORD_WIDTH-1:0] o_out_magnitude,
    output logic        [cpc_pkg::ANGLE_WIDTH-1:0] o_out_angle,
    output logic                                 o_saturated
);
    import cpc_pkg::*;

    localparam int MAG_RAW_W = XPROD_W - GAIN_FRAC - FRAC_BITS;
    localparam int RECT_SH   = GAIN_FRAC - FRAC_BITS;

    localparam logic [MPROD_W-1:0] RECT_HALF = MPROD_W'(1) << (RECT_SH - 1);
    localparam logic [XPROD_W-1:0] MAG_HALF  = XPROD_W'(1) << (GAIN_FRAC + FRAC_BITS - 1);
    localparam logic signed [DW:0]  ROUND_HALF = (DW+1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ZW-1:0] Z_HALF    = ZW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [DW-FRAC_BITS:0] CMAX =
        (DW-FRAC_BITS+1)'((1 << (COORD_WIDTH - 1)) - 1);
    localparam logic signed [DW-FRAC_BITS:0] CMIN = -CMAX - (DW-FRAC_BITS+1)'(1);
    localparam logic [MAG_RAW_W-1:0] MAG_MAX = MAG_RAW_W'((1 << COORD_WIDTH) - 1);

    typedef struct packed {
        logic                          valid;
        logic                          kind;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic [ANGLE_WIDTH-1:0]        angle;
        logic [MPROD_W-1:0]            prod;
    } t_pre;

    typedef struct packed {
        logic                   valid;
        logic                   kind;
        logic                   origin;
        logic [ANGLE_WIDTH-1:0] angle;
        logic [XPROD_W-1:0]     mprod;
        logic signed [ZW-1:0]   total;
        logic signed [DW:0]     rx;
        logic signed [DW:0]     ry;
    } t_fin;

    typedef struct packed {
        logic                          valid;
        logic                          kind;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-1:0]        mag;
        logic [ANGLE_WIDTH-1:0]        angle;
        logic                          sat;
    } t_out;

    t_pre  r_p1, n_p1;
    t_cord r_p2, n_p2;
    t_cord w_cord;
    t_fin  r_q1, n_q1;
    t_out  r_q2, n_q2;

    assign busy = 1'b0;

    // stage 1: angle wrap and magnitude gain product
    always_comb begin
        n_p1.valid = start && !busy;
        n_p1.kind  = i_kind;
        n_p1.x     = i_in_x;
        n_p1.y     = i_in_y;
        n_p1.angle = (i_in_angle >= ANGLE_FULL) ? i_in_angle - ANGLE_FULL : i_in_angle;
        n_p1.prod  = MPROD_W'(i_in_magnitude) * MPROD_W'(GAIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= '0;
        end else begin
            r_p1 <= n_p1;
        end
    end

    // stage 2: cordic start vector, half-plane or quadrant fold
    logic signed [DW-1:0] w_xs;
    logic signed [DW-1:0] w_ys;
    logic signed [ZW-1:0] w_za;
    logic [MPROD_W-1:0]   w_rnd;

    assign w_xs  = DW'(r_p1.x);
    assign w_ys  = DW'(r_p1.y);
    assign w_za  = ZW'(r_p1.angle) <<< FRAC_BITS;
    assign w_rnd = r_p1.prod + RECT_HALF;

    always_comb begin
        n_p2        = '0;
        n_p2.valid  = r_p1.valid;
        n_p2.kind   = r_p1.kind;
        n_p2.angle  = r_p1.angle;
        if (r_p1.kind == KIND_POLAR) begin
            n_p2.origin = (r_p1.x == '0) && (r_p1.y == '0);
            if (r_p1.x < 0) begin
                n_p2.flip = 1'b1;
                n_p2.x    = (-w_xs) <<< FRAC_BITS;
                n_p2.y    = (-w_ys) <<< FRAC_BITS;
            end else begin
                n_p2.x = w_xs <<< FRAC_BITS;
                n_p2.y = w_ys <<< FRAC_BITS;
            end
        end else begin
            n_p2.x = DW'(w_rnd >> RECT_SH);
            if (r_p1.angle > ANGLE_Q1 && r_p1.angle <= ANGLE_Q3) begin
                n_p2.flip = 1'b1;
                n_p2.z    = w_za - Z_180;
            end else if (r_p1.angle > ANGLE_Q3) begin
                n_p2.z = w_za - Z_360;
            end else begin
                n_p2.z = w_za;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2 <= '0;
        end else begin
            r_p2 <= n_p2;
        end
    end

    cpc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (r_p2),
        .o_stage (w_cord)
    );

    // finish stage 1: gain product, angle offset, rect rounding
    logic signed [ZW-1:0] w_tot0;
    logic signed [DW:0]   w_cx;
    logic signed [DW:0]   w_cy;

    assign w_tot0 = (w_cord.flip ? Z_180 : ZW'(0)) + w_cord.z;
    assign w_cx   = (DW+1)'(w_cord.x);
    assign w_cy   = (DW+1)'(w_cord.y);

    always_comb begin
        n_q1        = '0;
        n_q1.valid  = w_cord.valid;
        n_q1.kind   = w_cord.kind;
        n_q1.origin = w_cord.origin;
        n_q1.angle  = w_cord.angle;
        n_q1.mprod  = XPROD_W'(w_cord.x[DW-2:0]) * XPROD_W'(GAIN);
        n_q1.total  = w_tot0[ZW-1] ? w_tot0 + Z_360 : w_tot0;
        n_q1.rx     = w_cord.flip ? ROUND_HALF - w_cx : w_cx + ROUND_HALF;
        n_q1.ry     = w_cord.flip ? ROUND_HALF - w_cy : w_cy + ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1 <= '0;
        end else begin
            r_q1 <= n_q1;
        end
    end

    // finish stage 2: magnitude and angle rounding, coordinate clipping
    logic [MAG_RAW_W-1:0]          w_mag;
    logic signed [ZW-1:0]          w_zr;
    logic [ANGLE_WIDTH-1:0]        w_ang;
    logic signed [DW-FRAC_BITS:0]  w_sx;
    logic signed [DW-FRAC_BITS:0]  w_sy;
    logic                          w_satx;
    logic                          w_saty;

    assign w_mag  = MAG_RAW_W'((r_q1.mprod + MAG_HALF) >> (GAIN_FRAC + FRAC_BITS));
    assign w_zr   = (r_q1.total + Z_HALF) >>> FRAC_BITS;
    assign w_ang  = w_zr[ANGLE_WIDTH-1:0];
    assign w_sx   = (DW-FRAC_BITS+1)'(r_q1.rx >>> FRAC_BITS);
    assign w_sy   = (DW-FRAC_BITS+1)'(r_q1.ry >>> FRAC_BITS);
    assign w_satx = (w_sx > CMAX) || (w_sx < CMIN);
    assign w_saty = (w_sy > CMAX) || (w_sy < CMIN);

    always_comb begin
        n_q2       = '0;
        n_q2.valid = r_q1.valid;
        n_q2.kind  = r_q1.kind;
        if (r_q1.kind == KIND_POLAR) begin
            if (!r_q1.origin) begin
                n_q2.mag   = (w_mag > MAG_MAX) ? COORD_WIDTH'(MAG_MAX)
                                               : w_mag[COORD_WIDTH-1:0];
                n_q2.angle = (w_ang >= ANGLE_FULL) ? w_ang - ANGLE_FULL : w_ang;
            end
        end else begin
            n_q2.angle = r_q1.angle;
            n_q2.sat   = w_satx || w_saty;
            priority if (w_sx > CMAX) begin
                n_q2.x = COORD_WIDTH'(CMAX);
            end else if (w_sx < CMIN) begin
                n_q2.x = COORD_WIDTH'(CMIN);
            end else begin
                n_q2.x = w_sx[COORD_WIDTH-1:0];
            end
            priority if (w_sy > CMAX) begin
                n_q2.y = COORD_WIDTH'(CMAX);
            end else if (w_sy < CMIN) begin
                n_q2.y = COORD_WIDTH'(CMIN);
            end else begin
                n_q2.y = w_sy[COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q2 <= '0;
        end else begin
            r_q2 <= n_q2;
        end
    end

    assign o_valid         = r_q2.valid;
    assign o_out_kind      = r_q2.kind;
    assign o_out_x         = r_q2.x;
    assign o_out_y         = r_q2.y;
    assign o_out_magnitude = r_q2.mag;
    assign o_out_angle     = r_q2.angle;
    assign o_saturated     = r_q2.sat;

`ifndef SYNTHESIS
    a_polar_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind == KIND_POLAR |->
            !o_saturated && o_out_x == '0 && o_out_y == '0)
        else $error("polar result carries rectangular fields");

    a_rect_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind == KIND_RECT |-> o_out_magnitude == '0)
        else $error("rectangular result carries a magnitude");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out_angle < ANGLE_FULL)
        else $error("result angle not below 360 degrees");

    a_finish_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q1.valid |=> o_valid)
        else $error("transaction lost in the finish stages");
`endif

endmodule

@@ hdl/cpc_cordic.sv @@
// unrolled cordic, one registered micro-rotation per stage, vectoring or rotation per item
`timescale 1ns / 1ps
module cpc_cordic (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cpc_pkg::t_cord i_stage,
    output cpc_pkg::t_cord o_stage
);
    import cpc_pkg::*;

    t_cord w_pipe [ITERATIONS+1];

    assign w_pipe[0] = i_stage;

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
        t_cord                n_stage;
        t_cord                r_stage;
        logic signed [DW-1:0] w_xsh;
        logic signed [DW-1:0] w_ysh;
        logic                 w_cw;

        assign w_xsh = w_pipe[k].x >>> k;
        assign w_ysh = w_pipe[k].y >>> k;
        // vectoring drives y to zero, rotation drives z to zero
        assign w_cw  = (w_pipe[k].kind == KIND_POLAR) ? !w_pipe[k].y[DW-1]
                                                      : w_pipe[k].z[ZW-1];

        always_comb begin
            n_stage = w_pipe[k];
            if (w_cw) begin
                n_stage.x = w_pipe[k].x + w_ysh;
                n_stage.y = w_pipe[k].y - w_xsh;
                n_stage.z = w_pipe[k].z + cpc_atan(k);
            end else begin
                n_stage.x = w_pipe[k].x - w_ysh;
                n_stage.y = w_pipe[k].y + w_xsh;
                n_stage.z = w_pipe[k].z - cpc_atan(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stage <= '0;
            end else begin
                r_stage <= n_stage;
            end
        end

        assign w_pipe[k+1] = r_stage;
    end

    assign o_stage = w_pipe[ITERATIONS];

endmodule
